// ===== hw/rtl/ddo_pkg.sv =====
`default_nettype none
package ddo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam int unsigned ATAN_LEN = 30;

  localparam int unsigned DIV_BITS = 51;
  localparam int unsigned DSR_BITS = 31;
  localparam int unsigned MUL_W    = 36;

  localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic [30:0]        TWO_PI_Q28  = 31'd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [32:0] ONE_Q16     = 33'sd65536;
  // Floor of 2^50 over 2*pi in Q3.28; the quotient estimate it gives is at most two short.
  localparam logic [35:0]        RECIP_2PI   = 36'd667544;

  localparam logic [2:0] REG_LINEAR_SPEED = 3'd0;
  localparam logic [2:0] REG_STEER_GAIN   = 3'd1;
  localparam logic [2:0] REG_WHEEL_BASE   = 3'd2;
  localparam logic [2:0] REG_MPP          = 3'd3;
  localparam logic [2:0] REG_SPEED_UNITS  = 3'd4;

  typedef struct packed {
    logic signed [15:0] left_delta;
    logic signed [15:0] right_delta;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } out_item_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    begin
      case (idx)
        5'd0:  v = 32'd210828714;
        5'd1:  v = 32'd124459457;
        5'd2:  v = 32'd65760959;
        5'd3:  v = 32'd33381290;
        5'd4:  v = 32'd16755422;
        5'd5:  v = 32'd8385879;
        5'd6:  v = 32'd4193963;
        5'd7:  v = 32'd2097109;
        5'd8:  v = 32'd1048571;
        5'd9:  v = 32'd524287;
        5'd10: v = 32'd262144;
        5'd11: v = 32'd131072;
        5'd12: v = 32'd65536;
        5'd13: v = 32'd32768;
        5'd14: v = 32'd16384;
        5'd15: v = 32'd8192;
        5'd16: v = 32'd4096;
        5'd17: v = 32'd2048;
        5'd18: v = 32'd1024;
        5'd19: v = 32'd512;
        5'd20: v = 32'd256;
        5'd21: v = 32'd128;
        5'd22: v = 32'd64;
        5'd23: v = 32'd32;
        5'd24: v = 32'd16;
        5'd25: v = 32'd8;
        5'd26: v = 32'd4;
        5'd27: v = 32'd2;
        5'd28: v = 32'd1;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ddo_mul.sv =====
`default_nettype none
module ddo_mul (
  input  wire logic                                   clk_i,
  input  wire logic signed [ddo_pkg::MUL_W-1:0]       a_i,
  input  wire logic signed [ddo_pkg::MUL_W-1:0]       b_i,
  output logic signed [2*ddo_pkg::MUL_W-1:0]          p_o
);
  import ddo_pkg::*;

  logic signed [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;
endmodule
`default_nettype wire

// ===== hw/rtl/ddo_div.sv =====
`default_nettype none
module ddo_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [ddo_pkg::DIV_BITS-1:0]    dividend_i,
  input  wire logic [ddo_pkg::DSR_BITS-1:0]    divisor_i,
  output logic                                 done_o,
  output logic [ddo_pkg::DIV_BITS-1:0]         quot_o
);
  import ddo_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_BITS);

  logic [DIV_BITS-1:0] dvd_q;
  logic [DSR_BITS-1:0] rem_q, dsr_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q, done_q;
  logic [DSR_BITS:0]   trial;
  logic                ge;

  // One restoring step per cycle: the quotient shifts in where the dividend shifts out.
  assign trial = {rem_q, dvd_q[DIV_BITS-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dvd_q  <= dividend_i;
        rem_q  <= '0;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= ge ? DSR_BITS'(trial - {1'b0, dsr_q}) : trial[DSR_BITS-1:0];
        dvd_q <= {dvd_q[DIV_BITS-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
endmodule
`default_nettype wire

// ===== hw/rtl/ddo_cordic.sv =====
`default_nettype none
module ddo_cordic #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] angle_i,
  output logic                    done_o,
  output logic signed [33:0]      cos_o,
  output logic signed [33:0]      sin_o
);
  import ddo_pkg::*;

  localparam int unsigned ITER  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int unsigned CNT_W = $clog2(ITER);

  logic signed [33:0] x_q, y_q, xs, ys;
  logic signed [31:0] z_q, at;
  logic [CNT_W-1:0]   i_q;
  logic               busy_q, done_q, flip_q;

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = $signed(atan_lut(5'(i_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      flip_q <= 1'b0;
      i_q    <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
        x_q    <= GAIN_Q30;
        y_q    <= '0;
        // Angles outside the right half plane are folded by pi and negated at the end.
        if (angle_i > HALF_PI_Q28) begin
          z_q    <= angle_i - PI_Q28;
          flip_q <= 1'b1;
        end else if (angle_i < -HALF_PI_Q28) begin
          z_q    <= angle_i + PI_Q28;
          flip_q <= 1'b1;
        end else begin
          z_q    <= angle_i;
          flip_q <= 1'b0;
        end
      end else if (busy_q) begin
        if (!z_q[31]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
        i_q <= i_q + 1'b1;
        if (i_q == CNT_W'(ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;
endmodule
`default_nettype wire

// ===== hw/rtl/diff_drive_odometry_steering_unit.sv =====
`default_nettype none
// Dead-reckoning odometry with a pose-tracking steering law. Each input transaction
// carries the left and right encoder pulse counts of one control tick; the unit
// updates its pose (x, y in Q16.16, heading in Q3.28) and returns one transaction
// with the two saturated 16 bit wheel speed commands. One tick at a time is in
// flight: the next tick can be accepted as soon as the result of the last one has
// moved into the output register, as long as that register is free. The time goes
// mostly to one restoring division of the 51 bit dividend for the heading
// increment on the divider, then one CORDIC iteration per cycle, and 15 passes
// through the single registered 36x36 multiplier, two of which reduce the heading
// modulo 2*pi by reciprocal multiplication. The next tick is accepted while the
// previous result still waits at the output. Configuration writes are always
// accepted and should be made between ticks.
module diff_drive_odometry_steering_unit #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ddo_pkg::in_item_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ddo_pkg::out_item_t       out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i
);
  import ddo_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0,  S_M1 = 5'd1,  S_M2 = 5'd2,  S_M3 = 5'd3;
  localparam logic [4:0] S_DV1  = 5'd4,  S_R1 = 5'd5,  S_CW = 5'd6,  S_P1 = 5'd7;
  localparam logic [4:0] S_P2   = 5'd8,  S_P3 = 5'd9,  S_P4 = 5'd10, S_P5 = 5'd11;
  localparam logic [4:0] S_P6   = 5'd12, S_P7 = 5'd13, S_P8 = 5'd14, S_P9 = 5'd15;
  localparam logic [4:0] S_C1   = 5'd16, S_C2 = 5'd17, S_C3 = 5'd18, S_OUT = 5'd19;
  localparam logic [4:0] S_R2   = 5'd20, S_R3 = 5'd21;

  logic [4:0] state_q, state_d;

  logic signed [18:0] lin_q;
  logic [19:0]        gain_q;
  logic [16:0]        wb_q;
  logic [20:0]        mpp_q;
  logic [30:0]        su_q;

  logic signed [31:0] pose_x_q, pose_y_q, heading_q;
  logic signed [15:0] l_q, r_q;
  logic               num_neg_q, hneg_q, side_q, mneg_q, out_valid_q;
  logic signed [20:0] half_q;
  logic signed [33:0] c_q, s_q;
  logic signed [71:0] acc_q;
  logic signed [41:0] g_q;
  logic signed [44:0] turn_q;
  logic [45:0]        m_q;
  logic [15:0]        left_q, right_q;
  logic [49:0]        hmag_q;
  out_item_t          out_q;

  logic signed [MUL_W-1:0]   ma, mb;
  logic signed [2*MUL_W-1:0] p;

  logic                div_start, div_done;
  logic [DIV_BITS-1:0] div_dvd, div_quot;
  logic [DSR_BITS-1:0] div_dsr;

  logic               cor_start, cor_done;
  logic signed [31:0] cor_ang;
  logic signed [33:0] cor_c, cor_s;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    begin
      if (v[33:31] == 3'b000 || v[33:31] == 3'b111) r = v[31:0];
      else if (v[33]) r = 32'sh8000_0000;
      else r = 32'sh7fff_ffff;
      return r;
    end
  endfunction

  // Helper signals for the heading update.
  logic signed [16:0] diff_lr, sum_lr;
  logic [37:0]        num_mag;
  logic [30:0]        wb_div;
  logic signed [51:0] dth, hsum;
  logic [49:0]        hmag;
  logic [32:0]        red_r;
  logic [30:0]        hrem;
  logic [30:0]        fm;
  logic signed [31:0] hnew;

  assign diff_lr = {r_q[15], r_q} - {l_q[15], l_q};
  assign sum_lr  = {r_q[15], r_q} + {l_q[15], l_q};
  assign num_mag = p[71] ? 38'(-p[37:0]) : p[37:0];
  assign wb_div  = (wb_q == '0) ? 31'd1 : {14'd0, wb_q};
  assign dth     = num_neg_q ? -$signed({2'b00, div_quot[49:0]})
                             : $signed({2'b00, div_quot[49:0]});
  assign hsum    = {{20{heading_q[31]}}, heading_q} + dth;
  assign hmag    = hsum[51] ? 50'(-hsum) : hsum[49:0];

  // The estimated quotient is at most two short, so the remainder is below 3*2*pi
  // and fits in 33 bits.
  assign red_r = hmag_q[32:0] - p[32:0];

  always_comb begin
    if (red_r >= {1'b0, TWO_PI_Q28, 1'b0}) begin
      hrem = 31'(red_r - {1'b0, TWO_PI_Q28, 1'b0});
    end else if (red_r >= {2'b00, TWO_PI_Q28}) begin
      hrem = 31'(red_r - {2'b00, TWO_PI_Q28});
    end else begin
      hrem = red_r[30:0];
    end
  end

  // Floor modulo of the heading sum, then folded into [-pi, pi).
  assign fm      = (hneg_q && hrem != '0) ? TWO_PI_Q28 - hrem : hrem;
  assign hnew    = ({1'b0, fm} >= PI_Q28) ? $signed({1'b0, fm}) - $signed({1'b0, TWO_PI_Q28})
                                          : $signed({1'b0, fm});

  // Pose and steering helpers.
  logic signed [33:0] newx, newy;
  logic signed [71:0] ke_sum;
  logic signed [44:0] turn_c;
  logic signed [45:0] cmd_a, cmd_b, cmd_sel;
  logic [71:0]        qsum;
  logic [55:0]        qv;
  logic               q_hi;
  logic [15:0]        cmd_res;

  assign newx   = {{2{pose_x_q[31]}}, pose_x_q} + {{8{p[55]}}, p[55:30]};
  assign newy   = {{2{pose_y_q[31]}}, pose_y_q} + {{8{p[55]}}, p[55:30]};
  assign ke_sum = acc_q + p;
  assign turn_c = acc_q[44:0] + {28'd0, p[32:16]};
  assign cmd_a  = {{27{lin_q[18]}}, lin_q} - {turn_c[44], turn_c};
  assign cmd_b  = {{27{lin_q[18]}}, lin_q} + {turn_q[44], turn_q};
  assign cmd_sel = (state_q == S_P9) ? cmd_a : cmd_b;

  assign qsum = 72'(acc_q) + {16'd0, p[71:16]};
  assign qv   = qsum[71:16];
  assign q_hi = |qv[55:16];

  always_comb begin
    if (!mneg_q) begin
      cmd_res = (q_hi || qv[15]) ? 16'h7fff : qv[15:0];
    end else begin
      cmd_res = (q_hi || (qv[15] && qv[14:0] != '0)) ? 16'h8000 : 16'(-qv[15:0]);
    end
  end

  // Divider and CORDIC launch.
  assign div_start = (state_q == S_M2);
  assign div_dvd   = {1'b0, num_mag, 12'd0};
  assign div_dsr   = wb_div;

  assign cor_start = (state_q == S_R3);
  assign cor_ang   = hnew;

  // Multiplier operand selection; each product is used in the following state.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      S_M1: begin
        ma = MUL_W'(diff_lr);
        mb = {15'd0, mpp_q};
      end
      S_M2: begin
        ma = MUL_W'(sum_lr);
        mb = {15'd0, mpp_q};
      end
      S_R1: begin
        ma = {4'd0, hmag_q[49:18]};
        mb = RECIP_2PI;
      end
      S_R2: begin
        ma = {16'd0, p[51:32]};
        mb = {5'd0, TWO_PI_Q28};
      end
      S_P1: begin
        ma = MUL_W'(half_q);
        mb = MUL_W'(c_q);
      end
      S_P2: begin
        ma = MUL_W'(half_q);
        mb = MUL_W'(s_q);
      end
      S_P3: begin
        ma = MUL_W'($signed({pose_x_q[31], pose_x_q}) - ONE_Q16);
        mb = MUL_W'(c_q);
      end
      S_P4: begin
        ma = MUL_W'($signed({pose_y_q[31], pose_y_q}) - ONE_Q16);
        mb = MUL_W'(s_q);
      end
      S_P5: begin
        ma = {16'd0, gain_q};
        mb = MUL_W'($signed(ke_sum[64:30]));
      end
      S_P7: begin
        ma = MUL_W'($signed(g_q[41:16]));
        mb = {19'd0, wb_q};
      end
      S_P8: begin
        ma = {20'd0, g_q[15:0]};
        mb = {19'd0, wb_q};
      end
      S_C1: begin
        ma = {6'd0, m_q[45:16]};
        mb = {5'd0, su_q};
      end
      S_C2: begin
        ma = {20'd0, m_q[15:0]};
        mb = {5'd0, su_q};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_M1;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3:   state_d = S_DV1;
      S_DV1:  if (div_done) state_d = S_R1;
      S_R1:   state_d = S_R2;
      S_R2:   state_d = S_R3;
      S_R3:   state_d = S_CW;
      S_CW:   if (cor_done) state_d = S_P1;
      S_P1:   state_d = S_P2;
      S_P2:   state_d = S_P3;
      S_P3:   state_d = S_P4;
      S_P4:   state_d = S_P5;
      S_P5:   state_d = S_P6;
      S_P6:   state_d = S_P7;
      S_P7:   state_d = S_P8;
      S_P8:   state_d = S_P9;
      S_P9:   state_d = S_C1;
      S_C1:   state_d = S_C2;
      S_C2:   state_d = S_C3;
      S_C3:   state_d = side_q ? S_OUT : S_C1;
      S_OUT:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      lin_q       <= 19'sd16384;
      gain_q      <= 20'd26214;
      wb_q        <= 17'd6907;
      mpp_q       <= 21'd29128;
      su_q        <= 31'd96632832;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      heading_q   <= '0;
      side_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_LINEAR_SPEED: lin_q  <= cfg_data_i[18:0];
          REG_STEER_GAIN:   gain_q <= cfg_data_i[19:0];
          REG_WHEEL_BASE:   wb_q   <= cfg_data_i[16:0];
          REG_MPP:          mpp_q  <= cfg_data_i[20:0];
          REG_SPEED_UNITS:  su_q   <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_R3:   heading_q <= hnew;
        S_P2:   pose_x_q <= sat32(newx);
        S_P3:   pose_y_q <= sat32(newy);
        S_P9:   side_q <= 1'b0;
        S_C3:   side_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        l_q <= in_data_i.left_delta;
        r_q <= in_data_i.right_delta;
      end
      S_M2:  num_neg_q <= p[71];
      S_M3:  half_q <= p[37:17];
      S_DV1: begin
        if (div_done) begin
          hneg_q <= hsum[51];
          hmag_q <= hmag;
        end
      end
      S_CW: begin
        if (cor_done) begin
          c_q <= cor_c;
          s_q <= cor_s;
        end
      end
      S_P4:  acc_q <= p;
      S_P6:  g_q <= {{23{lin_q[18]}}, lin_q} + p[57:16];
      S_P8:  acc_q <= p;
      S_P9: begin
        turn_q <= turn_c;
        mneg_q <= cmd_sel[45];
        m_q    <= cmd_sel[45] ? 46'(-cmd_sel) : cmd_sel;
      end
      S_C2:  acc_q <= p;
      S_C3: begin
        if (!side_q) begin
          left_q <= cmd_res;
          mneg_q <= cmd_sel[45];
          m_q    <= cmd_sel[45] ? 46'(-cmd_sel) : cmd_sel;
        end else begin
          right_q <= cmd_res;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.left_speed  <= left_q;
          out_q.right_speed <= right_q;
        end
      end
      default: ;
    endcase
  end

  ddo_mul u_mul (
    .clk_i (clk_i),
    .a_i   (ma),
    .b_i   (mb),
    .p_o   (p)
  );

  ddo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_ang),
    .done_o  (cor_done),
    .cos_o   (cor_c),
    .sin_o   (cor_s)
  );

  // Both commands are staged and move into out_q together once the output is free.
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;
endmodule
`default_nettype wire
